[sv/uutp_pkg.sv]
`default_nettype none
package uutp_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned PosWidth   = 6;
    localparam int unsigned IndexWidth = 4;
    localparam int unsigned CountWidth = 5;

    localparam logic [PosWidth-1:0]   TextLen     = 6'd38;
    localparam logic [PosWidth-1:0]   PosMax      = 6'd63;
    localparam logic [CountWidth-1:0] UuidBytes   = 5'd16;
    localparam logic [CharWidth-1:0]  OpenBrace   = 8'h7B;
    localparam logic [CharWidth-1:0]  CloseBrace  = 8'h7D;
    localparam logic [CharWidth-1:0]  DashChar    = 8'h2D;
    localparam logic [PosWidth-1:0]   DashSlotA   = 6'd9;
    localparam logic [PosWidth-1:0]   DashSlotB   = 6'd14;
    localparam logic [PosWidth-1:0]   DashSlotC   = 6'd19;
    localparam logic [PosWidth-1:0]   DashSlotD   = 6'd24;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_NO_OPEN     = 3'd2,
        ST_NO_CLOSE    = 3'd3,
        ST_SIZE        = 3'd4,
        ST_BAD_CHAR    = 3'd5,
        ST_DASH        = 3'd6
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [CharWidth-1:0] ch;
        logic                 last;
        logic                 no_char;
    } char_item_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] nibble;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [CharWidth-1:0] c);
        hex_digit_t d;
        d.hit    = 1'b1;
        d.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.nibble = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            d.nibble = c[3:0] + 4'd9;
        end
        else
        begin
            d.hit = 1'b0;
        end
        return d;
    endfunction

    function automatic logic is_dash_slot(input logic [PosWidth-1:0] p);
        return (p == DashSlotA) || (p == DashSlotB) || (p == DashSlotC) || (p == DashSlotD);
    endfunction

endpackage
`default_nettype wire

[sv/uutp_char_if.sv]
`default_nettype none
interface uutp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;
    logic       no_char;

    modport source (output valid, output ch, output last, output no_char, input ready);
    modport sink   (input valid, input ch, input last, input no_char, output ready);
endinterface
`default_nettype wire

[sv/uutp_result_if.sv]
`default_nettype none
interface uutp_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    logic [2:0] status;

    modport source (output valid, output kind, output byte_value, output byte_index,
                    output status, input ready);
    modport sink   (input valid, input kind, input byte_value, input byte_index,
                    input status, output ready);
endinterface
`default_nettype wire

[sv/uutp_input_stage.sv]
`default_nettype none
module uutp_input_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    uutp_char_if.sink                char_in,
    output uutp_pkg::char_item_t     item,
    output logic                     item_valid,
    input  wire logic                advance
);
    import uutp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    logic       take;

    // Accept while empty or while the held transaction moves on this cycle.
    assign char_in.ready = !valid_reg || advance;
    assign take          = char_in.valid && char_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.ch      <= char_in.ch;
            item_reg.last    <= char_in.last;
            item_reg.no_char <= char_in.no_char;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;
endmodule
`default_nettype wire

[sv/uutp_parse_core.sv]
`default_nettype none
module uutp_parse_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire uutp_pkg::char_item_t item,
    input  wire logic                item_valid,
    output logic                     advance,
    uutp_result_if.source            result_out
);
    import uutp_pkg::*;

    logic [PosWidth-1:0]   pos_reg,   pos_next;
    logic [3:0]            hi_reg,    hi_next;
    logic                  phase_reg, phase_next;
    logic [CountWidth-1:0] bytes_reg, bytes_next;
    logic                  open_reg,  open_next;
    logic                  bad_reg,   bad_next;
    logic                  dash_reg,  dash_next;

    logic                  res_valid_reg, res_valid_next;
    kind_t                 kind_reg,  kind_next;
    logic [7:0]            value_reg, value_next;
    logic [IndexWidth-1:0] index_reg, index_next;
    status_t               status_reg, status_next;

    logic                  emit;
    logic                  open_ok;
    hex_digit_t            digit;
    logic                  slot;

    assign advance = item_valid && (!res_valid_reg || result_out.ready);
    assign digit   = hex_decode(item.ch);
    assign slot    = is_dash_slot(pos_reg);
    assign open_ok = (pos_reg == '0) ? (item.ch == OpenBrace) : open_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        hi_next     = hi_reg;
        phase_next  = phase_reg;
        bytes_next  = bytes_reg;
        open_next   = open_reg;
        bad_next    = bad_reg;
        dash_next   = dash_reg;
        emit        = 1'b0;
        kind_next   = KIND_DATA;
        value_next  = 8'd0;
        index_next  = '0;
        status_next = ST_OK;

        if (advance)
        begin
            if (item.no_char || item.last)
            begin
                if (item.no_char)
                begin
                    emit = item.last;
                    status_next = ST_EMPTY;
                end
                else
                begin
                    emit = 1'b1;
                    if (!open_ok)
                        status_next = ST_NO_OPEN;
                    else if (item.ch != CloseBrace)
                        status_next = ST_NO_CLOSE;
                    else if (pos_reg != TextLen - 6'd1)
                        status_next = ST_SIZE;
                    else if (bad_reg)
                        status_next = ST_BAD_CHAR;
                    else if (dash_reg)
                        status_next = ST_DASH;
                    else
                        status_next = ST_OK;
                end
                kind_next = KIND_STATUS;
                // Drop all string state once the status goes out.
                if (emit)
                begin
                    pos_next   = '0;
                    hi_next    = 4'd0;
                    phase_next = 1'b0;
                    bytes_next = '0;
                    open_next  = 1'b0;
                    bad_next   = 1'b0;
                    dash_next  = 1'b0;
                end
            end
            else if (pos_reg == '0)
            begin
                open_next = (item.ch == OpenBrace);
                pos_next  = 6'd1;
            end
            else
            begin
                if (pos_reg != PosMax)
                    pos_next = pos_reg + 6'd1;
                if (digit.hit)
                begin
                    if (slot)
                        dash_next = 1'b1;
                    if (!phase_reg)
                    begin
                        hi_next    = digit.nibble;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (bytes_reg < UuidBytes)
                        begin
                            emit       = 1'b1;
                            value_next = {hi_reg, digit.nibble};
                            index_next = bytes_reg[IndexWidth-1:0];
                            bytes_next = bytes_reg + 5'd1;
                        end
                    end
                end
                else if (item.ch == DashChar)
                begin
                    if (!slot)
                        dash_next = 1'b1;
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
        end

        if (emit)
            res_valid_next = 1'b1;
        else if (result_out.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hi_reg        <= 4'd0;
            phase_reg     <= 1'b0;
            bytes_reg     <= '0;
            open_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            dash_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            hi_reg        <= hi_next;
            phase_reg     <= phase_next;
            bytes_reg     <= bytes_next;
            open_reg      <= open_next;
            bad_reg       <= bad_next;
            dash_reg      <= dash_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            index_reg  <= index_next;
            status_reg <= status_next;
        end
    end

    assign result_out.valid      = res_valid_reg;
    assign result_out.kind       = kind_reg;
    assign result_out.byte_value = value_reg;
    assign result_out.byte_index = index_reg;
    assign result_out.status     = status_reg;
endmodule
`default_nettype wire

[sv/uuid_text_parser_unit.sv]
// Path: an accepted character is held in the input register; the parse core moves it on
// while the result register is empty or being taken, and registers its result, if it gives one.
// Throughput: one character per cycle while the receiver takes results; the input register
// and the result register each pass a transaction on while the next one is taken.
// Reset (rst_n low, asynchronous): parse state and both valid flags clear;
// the next character starts a new string.
`default_nettype none
module uuid_text_parser_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    uutp_char_if.sink     char_in,
    uutp_result_if.source result_out
);
    import uutp_pkg::*;

    char_item_t item;
    logic       item_valid;
    logic       advance;

    uutp_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .item       (item),
        .item_valid (item_valid),
        .advance    (advance)
    );

    uutp_parse_core u_parse_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .advance    (advance),
        .result_out (result_out)
    );
endmodule
`default_nettype wire

[test/tb_top.sv]
module tb_top;
    import uutp_pkg::*;

    localparam logic [7:0] DigitZero = 8'h30;
    localparam logic [7:0] UpperA    = 8'h41;
    localparam logic [7:0] LowerA    = 8'h61;
    localparam int RandomItems = 950;
    localparam int CalmTail    = 100;
    localparam int HoldCycles  = 80;
    localparam int DrainCycles = 12;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [3:0] index;
        status_t    status;
    } uuid_result_t;

    logic clk;
    logic rst_n;

    uutp_char_if   char_bus();
    uutp_result_if result_bus();

    uuid_text_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_bus),
        .result_out (result_bus)
    );

    char_item_t   pending_chars[$];
    uuid_result_t expected_results[$];
    logic [7:0]   text_buf[$];

    int total_items    = 0;
    int string_items   = 0;
    int accepted_chars = 0;
    int error_count    = 0;
    int send_gap       = 0;
    int recv_stall     = 0;

    logic hold_long    = 1'b0;
    logic send_idle_on = 1'b1;
    logic recv_idle_on = 1'b1;

    char_item_t   next_char;
    char_item_t   taken_char;
    uuid_result_t next_expected;

    // Parser state as the block should hold it
    logic [5:0] char_pos;
    logic [3:0] hi_nibble;
    logic       low_phase;
    logic [4:0] bytes_out;
    logic       open_seen;
    logic       bad_seen;
    logic       dash_err;

    initial
    begin
        char_pos  = '0;
        hi_nibble = '0;
        low_phase = 1'b0;
        bytes_out = '0;
        open_seen = 1'b0;
        bad_seen  = 1'b0;
        dash_err  = 1'b0;
    end

    function automatic void close_string(input status_t st);
        uuid_result_t res;
        res.kind   = KIND_STATUS;
        res.value  = '0;
        res.index  = '0;
        res.status = st;
        expected_results.push_back(res);
        char_pos  = '0;
        hi_nibble = '0;
        low_phase = 1'b0;
        bytes_out = '0;
        open_seen = 1'b0;
        bad_seen  = 1'b0;
        dash_err  = 1'b0;
    endfunction

    function automatic void predict_char(input char_item_t it);
        uuid_result_t res;
        logic [5:0]   pos;
        logic [7:0]   offset;
        logic         hit;
        logic         open_ok;
        logic         on_slot;
        status_t      st;
        if (it.no_char)
        begin
            if (it.last)
            begin
                close_string(ST_EMPTY);
            end
            return;
        end
        if (it.last)
        begin
            open_ok = (char_pos == '0) ? (it.ch == OpenBrace) : open_seen;
            if (!open_ok)
                st = ST_NO_OPEN;
            else if (it.ch != CloseBrace)
                st = ST_NO_CLOSE;
            else if (char_pos != TextLen - 6'd1)
                st = ST_SIZE;
            else if (bad_seen)
                st = ST_BAD_CHAR;
            else if (dash_err)
                st = ST_DASH;
            else
                st = ST_OK;
            close_string(st);
            return;
        end
        if (char_pos == '0)
        begin
            open_seen = (it.ch == OpenBrace);
            char_pos  = 6'd1;
            return;
        end
        pos = char_pos;
        if (char_pos != PosMax)
        begin
            char_pos = char_pos + 6'd1;
        end
        on_slot = (pos == DashSlotA) || (pos == DashSlotB) ||
                  (pos == DashSlotC) || (pos == DashSlotD);
        hit    = 1'b1;
        offset = '0;
        if (it.ch >= DigitZero && it.ch <= DigitZero + 8'd9)
            offset = it.ch - DigitZero;
        else if (it.ch >= UpperA && it.ch <= UpperA + 8'd5)
            offset = it.ch - UpperA + 8'd10;
        else if (it.ch >= LowerA && it.ch <= LowerA + 8'd5)
            offset = it.ch - LowerA + 8'd10;
        else
            hit = 1'b0;
        if (hit)
        begin
            if (on_slot)
            begin
                dash_err = 1'b1;
            end
            if (!low_phase)
            begin
                hi_nibble = offset[3:0];
                low_phase = 1'b1;
            end
            else
            begin
                low_phase = 1'b0;
                // drop bytes past the sixteenth
                if (bytes_out < UuidBytes)
                begin
                    res.kind   = KIND_DATA;
                    res.value  = {hi_nibble, offset[3:0]};
                    res.index  = bytes_out[3:0];
                    res.status = ST_OK;
                    expected_results.push_back(res);
                    bytes_out = bytes_out + 5'd1;
                end
            end
        end
        else if (it.ch == DashChar)
        begin
            if (!on_slot)
            begin
                dash_err = 1'b1;
            end
        end
        else
        begin
            bad_seen = 1'b1;
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
        begin
            return DigitZero + {4'd0, v};
        end
        return (upper ? UpperA : LowerA) + {4'd0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] random_hex();
        return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_item(input logic [7:0] ch, input logic last, input logic no_char);
        char_item_t it;
        it.ch      = ch;
        it.last    = last;
        it.no_char = no_char;
        pending_chars.push_back(it);
        total_items++;
        if (!no_char || last)
        begin
            string_items++;
        end
    endtask

    task automatic send_text(input bit end_empty);
        foreach (text_buf[i])
        begin
            if ($urandom_range(0, 23) == 0)
            begin
                push_item(random_byte(), 1'b0, 1'b1);
            end
            push_item(text_buf[i], (i == text_buf.size() - 1) && !end_empty, 1'b0);
        end
        if (end_empty)
        begin
            push_item(random_byte(), 1'b1, 1'b1);
        end
    endtask

    task automatic build_uuid_text();
        text_buf.delete();
        text_buf.push_back(OpenBrace);
        for (int p = 1; p < 37; p++)
        begin
            if (p == DashSlotA || p == DashSlotB || p == DashSlotC || p == DashSlotD)
                text_buf.push_back(DashChar);
            else
                text_buf.push_back(random_hex());
        end
        text_buf.push_back(CloseBrace);
    endtask

    task automatic corrupt_text(output bit end_empty);
        int idx;
        int len;
        end_empty = 1'b0;
        idx = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 7))
            0:
            begin
                text_buf[idx] = random_byte();
            end
            1:
            begin
                // hex digit on a dash slot, or a dash at a random inner position
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: text_buf[DashSlotA] = random_hex();
                        1: text_buf[DashSlotB] = random_hex();
                        2: text_buf[DashSlotC] = random_hex();
                        default: text_buf[DashSlotD] = random_hex();
                    endcase
                end
                else
                begin
                    text_buf[$urandom_range(1, 36)] = DashChar;
                end
            end
            2:
            begin
                text_buf.delete(idx);
            end
            3:
            begin
                text_buf.insert(idx, ($urandom_range(0, 1) == 0) ? random_hex() : random_byte());
            end
            4:
            begin
                len = $urandom_range(1, 37);
                while (text_buf.size() > len)
                begin
                    void'(text_buf.pop_back());
                end
            end
            5:
            begin
                // run past the position ceiling now and then
                len = $urandom_range(1, 40);
                repeat (len)
                begin
                    text_buf.insert(text_buf.size() - 1, random_hex());
                end
            end
            6:
            begin
                end_empty = 1'b1;
                len = $urandom_range(0, 37);
                while (text_buf.size() > len)
                begin
                    void'(text_buf.pop_back());
                end
            end
            default:
            begin
                text_buf.delete();
                len = $urandom_range(1, 12);
                repeat (len)
                begin
                    text_buf.push_back(random_byte());
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : stimulus
        bit end_empty;
        int target;
        // empty strings, with and without a leading idle step
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        // single character strings
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(OpenBrace, 1'b1, 1'b0);
        text_buf = '{OpenBrace, CloseBrace};
        send_text(1'b0);
        text_buf = '{OpenBrace, hex_char(4'hF, 1'b0), hex_char(4'hF, 1'b1), CloseBrace};
        send_text(1'b0);
        text_buf = '{OpenBrace, DigitZero, DigitZero, DashChar, CloseBrace};
        send_text(1'b0);
        text_buf = '{8'h78, CloseBrace};
        send_text(1'b0);
        // string cut short by an end without character
        text_buf = '{OpenBrace, DigitZero};
        send_text(1'b1);

        target = string_items + RandomItems;
        while (string_items < target)
        begin
            build_uuid_text();
            end_empty = 1'b0;
            if ($urandom_range(0, 9) < 4)
            begin
                corrupt_text(end_empty);
            end
            if (text_buf.size() == 0)
            begin
                end_empty = 1'b1;
            end
            send_text(end_empty);
        end
    end

    // Sender: one transaction per handshake, random gaps until the tail
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_bus.valid   <= 1'b0;
            char_bus.ch      <= '0;
            char_bus.last    <= 1'b0;
            char_bus.no_char <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                taken_char.ch      = char_bus.ch;
                taken_char.last    = char_bus.last;
                taken_char.no_char = char_bus.no_char;
                predict_char(taken_char);
                accepted_chars++;
            end
            if ($urandom_range(0, 63) == 0)
            begin
                send_idle_on = !send_idle_on;
            end
            if (!char_bus.valid || char_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    char_bus.valid <= 1'b0;
                end
                else if (send_idle_on && !hold_long && pending_chars.size() > CalmTail &&
                         $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 18) - 1;
                    char_bus.valid <= 1'b0;
                end
                else if (pending_chars.size() != 0)
                begin
                    next_char = pending_chars.pop_front();
                    char_bus.ch      <= next_char.ch;
                    char_bus.last    <= next_char.last;
                    char_bus.no_char <= next_char.no_char;
                    char_bus.valid   <= 1'b1;
                end
                else
                begin
                    char_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
            begin
                recv_idle_on = !recv_idle_on;
            end
            if (hold_long)
            begin
                result_bus.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                result_bus.ready <= 1'b0;
            end
            else if (recv_idle_on && pending_chars.size() > CalmTail &&
                     $urandom_range(0, 7) == 0)
            begin
                recv_stall = $urandom_range(1, 18) - 1;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (accepted_chars < 150)
        begin
            @(posedge clk);
        end
        hold_long <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_long <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: kind %0d status %0d",
                                          result_bus.kind, result_bus.status));
            end
            else
            begin
                next_expected = expected_results.pop_front();
                if (result_bus.kind !== next_expected.kind)
                    report_mismatch($sformatf("kind %0d, want %0d",
                                              result_bus.kind, next_expected.kind));
                if (result_bus.byte_value !== next_expected.value)
                    report_mismatch($sformatf("byte_value %02h, want %02h",
                                              result_bus.byte_value, next_expected.value));
                if (result_bus.byte_index !== next_expected.index)
                    report_mismatch($sformatf("byte_index %0d, want %0d",
                                              result_bus.byte_index, next_expected.index));
                if (result_bus.status !== next_expected.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              result_bus.status, next_expected.status));
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (accepted_chars != total_items || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        // catch any stray result after the last one
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
            $display("[uuid_text_parser_unit] OK");
        else
            $display("[uuid_text_parser_unit] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[uuid_text_parser_unit] ERROR");
        $finish;
    end

endmodule
